/* rtl/rhpm_pkg.sv */
// shared types and constants of the rolling hash pattern matcher
package rhpm_pkg;

    localparam int BYTE_W     = 8;
    localparam int HASH_W     = 16;
    localparam int LEN_W      = 4;
    localparam int PAT_W      = 64;
    localparam int MM_W       = 17;
    localparam int MM_CNT_W   = 5;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int START_W    = 32;
    localparam int PIDX_W     = 3;

    localparam logic [1:0] REG_PATTERN = 2'd0;
    localparam logic [1:0] REG_LENGTH  = 2'd1;
    localparam logic [1:0] REG_RADIX   = 2'd2;
    localparam logic [1:0] REG_MODULUS = 2'd3;

    localparam logic [LEN_W-1:0]  LENGTH_RESET  = 4'd1;
    localparam logic [HASH_W-1:0] RADIX_RESET   = 16'd256;
    localparam logic [HASH_W-1:0] MODULUS_RESET = 16'd101;
    localparam logic [HASH_W-1:0] MODULUS_MIN   = 16'd2;

    typedef enum logic [2:0] {
        OP_RADIX = 3'd0,
        OP_POWER = 3'd1,
        OP_PHASH = 3'd2,
        OP_SUB   = 3'd3,
        OP_ROLL  = 3'd4,
        OP_GROW  = 3'd5
    } op_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_REF_D  = 8'b0000_0010,
        ST_REF_H  = 8'b0000_0100,
        ST_REF_P  = 8'b0000_1000,
        ST_SUB    = 8'b0001_0000,
        ST_ROLL   = 8'b0010_0000,
        ST_GROW   = 8'b0100_0000,
        ST_COMMIT = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic              in_ready;
        logic              accept;
        logic              start;
        op_t               op;
        logic              refresh_init;
        logic              load_d;
        logic              load_h;
        logic              load_p;
        logic              load_sub;
        logic              commit;
        logic [PIDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic             mm_done;
        logic             win_full;
        logic             out_free;
        logic             cfg_wr;
        logic [LEN_W-1:0] len;
    } status_t;

endpackage

/* rtl/rolling_hash_pattern_matcher_core.sv */
// top level of the rolling hash pattern matcher
// Rabin-Karp text search, one text byte per transaction and one result transaction per
// byte. All modular arithmetic runs on one shared bit-serial multiply-add unit, with one
// operation per byte while the window fills and two once it is full (one operation removes
// the leaving byte, one folds in the new byte). Any register write triggers a refresh of
// the pattern hash and leading power, during which no byte is taken; it also runs once
// after reset. A finished result waits in an output register while the next byte is
// taken. Registers sit at byte addresses 0, 8, 16 and 24.
module rolling_hash_pattern_matcher_core #(
    parameter int MAX_PATTERN = 8,
    parameter int INDEX_BITS  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rhpm_pkg::BYTE_W-1:0]         s_text_byte,
    input  logic                                s_end_of_text,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_window_full,
    output logic [rhpm_pkg::HASH_W-1:0]         m_window_hash,
    output logic                                m_hash_hit,
    output logic                                m_match_found,
    output logic [rhpm_pkg::START_W-1:0]        m_match_start,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rhpm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rhpm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rhpm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import rhpm_pkg::*;

    cmd_t    cmd;
    status_t status;

    rhpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd)
    );

    rhpm_datapath #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX_BITS  (INDEX_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_window_full (m_window_full),
        .m_window_hash (m_window_hash),
        .m_hash_hit    (m_hash_hit),
        .m_match_found (m_match_found),
        .m_match_start (m_match_start),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata)
    );

    assign s_ready = cmd.in_ready;
    assign pready  = 1'b1;

endmodule

/* rtl/rhpm_modmul.sv */
// bit-serial modular multiply-add unit: (x * y + z) mod q, y below q
module rhpm_modmul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [rhpm_pkg::MM_W-1:0]      x,
    input  logic [rhpm_pkg::HASH_W-1:0]    y,
    input  logic [rhpm_pkg::MM_W-1:0]      z,
    input  logic [rhpm_pkg::HASH_W-1:0]    q,
    output logic                           done,
    output logic [rhpm_pkg::HASH_W-1:0]    result
);
    import rhpm_pkg::*;

    localparam int SUM_W = HASH_W + 2;

    logic [HASH_W-1:0]   acc_reg, acc_next;
    logic [MM_W-1:0]     xs_reg, zs_reg;
    logic [MM_CNT_W-1:0] cnt_reg;
    logic                busy_reg, done_reg;
    logic [SUM_W-1:0]    sum, q1, q2;

    always_comb begin
        q1  = {2'b00, q};
        q2  = {1'b0, q, 1'b0};
        sum = {1'b0, acc_reg, 1'b0}
            + (xs_reg[MM_W-1] ? {2'b00, y} : '0)
            + SUM_W'(zs_reg[MM_W-1]);
        if (sum >= q2) begin
            acc_next = HASH_W'(sum - q2);
        end else if (sum >= q1) begin
            acc_next = HASH_W'(sum - q1);
        end else begin
            acc_next = HASH_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == MM_CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MM_CNT_W'(MM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - MM_CNT_W'(1);
                if (cnt_reg == MM_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            xs_reg  <= x;
            zs_reg  <= z;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            xs_reg  <= {xs_reg[MM_W-2:0], 1'b0};
            zs_reg  <= {zs_reg[MM_W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

/* rtl/rhpm_ctrl.sv */
// controller state machine: derived value refresh and per-byte sequencing
module rhpm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  rhpm_pkg::status_t status,
    output rhpm_pkg::cmd_t    cmd
);
    import rhpm_pkg::*;

    state_t           state_reg, state_next;
    logic             launch_reg, launch_next;
    logic             pend_reg, pend_next;
    logic [LEN_W-1:0] iter_reg, iter_next;
    logic [LEN_W-1:0] iter_inc;

    assign iter_inc = iter_reg + LEN_W'(1);

    always_comb begin
        state_next  = state_reg;
        launch_next = 1'b0;
        iter_next   = iter_reg;
        pend_next   = pend_reg | status.cfg_wr;

        cmd              = '0;
        cmd.start        = launch_reg;
        cmd.op           = OP_GROW;
        cmd.idx          = iter_reg[PIDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = !pend_reg;
                if (pend_reg) begin
                    cmd.refresh_init = 1'b1;
                    pend_next        = status.cfg_wr;
                    state_next       = ST_REF_D;
                    launch_next      = 1'b1;
                end else if (s_valid) begin
                    cmd.accept  = 1'b1;
                    state_next  = status.win_full ? ST_SUB : ST_GROW;
                    launch_next = 1'b1;
                end
            end
            ST_REF_D: begin
                cmd.op = OP_RADIX;
                if (status.mm_done) begin
                    cmd.load_d  = 1'b1;
                    launch_next = 1'b1;
                    if (status.len > LEN_W'(1)) begin
                        state_next = ST_REF_H;
                        iter_next  = LEN_W'(1);
                    end else begin
                        state_next = ST_REF_P;
                        iter_next  = '0;
                    end
                end
            end
            ST_REF_H: begin
                cmd.op = OP_POWER;
                if (status.mm_done) begin
                    cmd.load_h  = 1'b1;
                    launch_next = 1'b1;
                    if (iter_inc < status.len) begin
                        iter_next = iter_inc;
                    end else begin
                        state_next = ST_REF_P;
                        iter_next  = '0;
                    end
                end
            end
            ST_REF_P: begin
                cmd.op = OP_PHASH;
                if (status.mm_done) begin
                    cmd.load_p = 1'b1;
                    if (iter_inc < status.len) begin
                        iter_next   = iter_inc;
                        launch_next = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SUB: begin
                cmd.op = OP_SUB;
                if (status.mm_done) begin
                    cmd.load_sub = 1'b1;
                    state_next   = ST_ROLL;
                    launch_next  = 1'b1;
                end
            end
            ST_ROLL: begin
                cmd.op = OP_ROLL;
                if (status.mm_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_GROW: begin
                cmd.op = OP_GROW;
                if (status.mm_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            pend_reg   <= 1'b1;
            iter_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            pend_reg   <= pend_next;
            iter_reg   <= iter_next;
        end
    end

endmodule

/* rtl/rhpm_datapath.sv */
// datapath: config registers, derived hash values, window, rolling hash and result register
module rhpm_datapath #(
    parameter int MAX_PATTERN = 8,
    parameter int INDEX_BITS  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rhpm_pkg::cmd_t                      cmd,
    output rhpm_pkg::status_t                   status,
    input  logic [rhpm_pkg::BYTE_W-1:0]         s_text_byte,
    input  logic                                s_end_of_text,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_window_full,
    output logic [rhpm_pkg::HASH_W-1:0]         m_window_hash,
    output logic                                m_hash_hit,
    output logic                                m_match_found,
    output logic [rhpm_pkg::START_W-1:0]        m_match_start,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rhpm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rhpm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rhpm_pkg::CFG_DATA_W-1:0]     prdata
);
    import rhpm_pkg::*;

    localparam int EXT_W = INDEX_BITS + START_W;

    logic [PAT_W-1:0]      pat_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [HASH_W-1:0]     radix_reg;
    logic [HASH_W-1:0]     mod_reg;
    logic [1:0]            cfg_idx;
    logic                  cfg_wr;

    logic [HASH_W-1:0]     d_reg, h_reg, p_reg, sub_reg, rh_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic                  last_reg;
    logic [BYTE_W-1:0]     win_reg [MAX_PATTERN];
    logic [BYTE_W-1:0]     win_new [MAX_PATTERN];
    logic [INDEX_BITS-1:0] bs_reg, bs_inc, diff;
    logic [EXT_W-1:0]      diff_ext;

    logic [LEN_W-1:0]      len, len_m1, jk;
    logic [HASH_W-1:0]     q;
    logic [BYTE_W-1:0]     old_byte;

    logic [MM_W-1:0]       mm_x, mm_z;
    logic [HASH_W-1:0]     mm_y, mm_result;
    logic                  mm_done;

    logic                  full_new, hit_new, match_new;
    logic [START_W-1:0]    start_new;

    logic                  out_valid_reg;
    logic                  out_full_reg, out_hit_reg, out_match_reg;
    logic [HASH_W-1:0]     out_hash_reg;
    logic [START_W-1:0]    out_start_reg;

    assign cfg_idx = paddr[CFG_ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg   <= '0;
            len_reg   <= LENGTH_RESET;
            radix_reg <= RADIX_RESET;
            mod_reg   <= MODULUS_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PATTERN: pat_reg   <= pwdata;
                REG_LENGTH:  len_reg   <= pwdata[LEN_W-1:0];
                REG_RADIX:   radix_reg <= pwdata[HASH_W-1:0];
                REG_MODULUS: mod_reg   <= pwdata[HASH_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PATTERN: prdata = pat_reg;
            REG_LENGTH:  prdata = CFG_DATA_W'(len_reg);
            REG_RADIX:   prdata = CFG_DATA_W'(radix_reg);
            REG_MODULUS: prdata = CFG_DATA_W'(mod_reg);
        endcase
    end

    always_comb begin
        if (len_reg == '0) begin
            len = LEN_W'(1);
        end else if (len_reg > LEN_W'(MAX_PATTERN)) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = len_reg;
        end
        q      = (mod_reg < MODULUS_MIN) ? MODULUS_MIN : mod_reg;
        len_m1 = len - LEN_W'(1);
    end

    always_comb begin
        old_byte = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (LEN_W'(k) == len_m1) begin
                old_byte = win_reg[k];
            end
        end
    end

    // operand selection for the shared modular unit
    always_comb begin
        mm_x = '0;
        mm_y = '0;
        mm_z = '0;
        unique case (cmd.op)
            OP_RADIX: begin
                mm_z = MM_W'(radix_reg);
            end
            OP_POWER: begin
                mm_x = MM_W'(h_reg);
                mm_y = d_reg;
            end
            OP_PHASH: begin
                mm_x = MM_W'(p_reg);
                mm_y = d_reg;
                mm_z = MM_W'(pat_reg[{cmd.idx, 3'b000} +: BYTE_W]);
            end
            OP_SUB: begin
                mm_x = MM_W'(old_byte);
                mm_y = h_reg;
            end
            OP_ROLL: begin
                mm_x = MM_W'(rh_reg) + MM_W'(q) - MM_W'(sub_reg);
                mm_y = d_reg;
                mm_z = MM_W'(byte_reg);
            end
            OP_GROW: begin
                mm_x = MM_W'(rh_reg);
                mm_y = d_reg;
                mm_z = MM_W'(byte_reg);
            end
            default: begin
                mm_x = '0;
            end
        endcase
    end

    rhpm_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .x       (mm_x),
        .y       (mm_y),
        .z       (mm_z),
        .q       (q),
        .done    (mm_done),
        .result  (mm_result)
    );

    always_comb begin
        win_new[0] = byte_reg;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_new[k] = win_reg[k-1];
        end
        bs_inc    = (bs_reg == '1) ? bs_reg : bs_reg + INDEX_BITS'(1);
        full_new  = bs_inc >= INDEX_BITS'(len);
        diff      = bs_inc - INDEX_BITS'(len);
        diff_ext  = EXT_W'(diff);
        start_new = '0;
        if (full_new) begin
            start_new = (diff_ext > EXT_W'(32'hFFFF_FFFF)) ? '1 : diff_ext[START_W-1:0];
        end
        hit_new   = full_new && (mm_result == p_reg);
        match_new = hit_new;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            jk = len_m1 - LEN_W'(k);
            if ((LEN_W'(k) < len)
                && (win_new[k] != pat_reg[{jk[PIDX_W-1:0], 3'b000} +: BYTE_W])) begin
                match_new = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.refresh_init) begin
            h_reg <= HASH_W'(1);
            p_reg <= '0;
        end else begin
            if (cmd.load_h) begin
                h_reg <= mm_result;
            end
            if (cmd.load_p) begin
                p_reg <= mm_result;
            end
        end
        if (cmd.load_d) begin
            d_reg <= mm_result;
        end
        if (cmd.load_sub) begin
            sub_reg <= mm_result;
        end
        if (cmd.accept) begin
            byte_reg <= s_text_byte;
            last_reg <= s_end_of_text;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rh_reg <= '0;
            bs_reg <= '0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_reg[k] <= '0;
            end
        end else if (cmd.commit) begin
            if (last_reg) begin
                rh_reg <= '0;
                bs_reg <= '0;
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    win_reg[k] <= '0;
                end
            end else begin
                rh_reg <= mm_result;
                bs_reg <= bs_inc;
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    win_reg[k] <= win_new[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_full_reg  <= full_new;
            out_hash_reg  <= mm_result;
            out_hit_reg   <= hit_new;
            out_match_reg <= match_new;
            out_start_reg <= start_new;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_window_full = out_full_reg;
    assign m_window_hash = out_hash_reg;
    assign m_hash_hit    = out_hit_reg;
    assign m_match_found = out_match_reg;
    assign m_match_start = out_start_reg;

    assign status.mm_done  = mm_done;
    assign status.win_full = bs_reg >= INDEX_BITS'(len);
    assign status.out_free = !out_valid_reg || m_ready;
    assign status.cfg_wr   = cfg_wr;
    assign status.len      = len;

endmodule

/* bench/tb_rolling_hash_pattern_matcher_core.sv */
// testbench of the rolling hash pattern matcher core: directed and random texts and search settings
module tb_rolling_hash_pattern_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rhpm_pkg::*;

    localparam int              PATTERN_MAX = 8;
    localparam longint unsigned SEEN_LIMIT  = 64'hFFFF_FFFF;
    localparam int              LONG_HOLD   = 2000;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } text_item_t;

    typedef struct packed {
        logic               full;
        logic [HASH_W-1:0]  hash;
        logic               hit;
        logic               match;
        logic [START_W-1:0] start;
    } scan_result_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_text_byte   = '0;
    logic                  s_end_of_text = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_window_full;
    logic [HASH_W-1:0]     m_window_hash;
    logic                  m_hash_hit;
    logic                  m_match_found;
    logic [START_W-1:0]    m_match_start;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    text_item_t   text_feed[$];
    scan_result_t predicted_scans[$];
    int           fail_count     = 0;
    bit           no_gaps        = 1'b0;
    bit           long_hold_req  = 1'b0;
    bit           long_hold_done = 1'b0;
    int           hold_left      = 0;

    // search settings and text state of the predictor
    logic [PAT_W-1:0]  cfg_pattern;
    logic [LEN_W-1:0]  cfg_length;
    logic [HASH_W-1:0] cfg_radix;
    logic [HASH_W-1:0] cfg_modulus;
    longint unsigned   pat_hash;
    longint unsigned   lead_power;
    longint unsigned   roll_hash;
    longint unsigned   seen_count;
    logic [BYTE_W-1:0] window_bytes[PATTERN_MAX];

    rolling_hash_pattern_matcher_core #(
        .MAX_PATTERN (PATTERN_MAX),
        .INDEX_BITS  (32)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_window_full (m_window_full),
        .m_window_hash (m_window_hash),
        .m_hash_hit    (m_hash_hit),
        .m_match_found (m_match_found),
        .m_match_start (m_match_start),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned active_length();
        if (cfg_length == 0) return 64'd1;
        if (cfg_length > PATTERN_MAX) return 64'(PATTERN_MAX);
        return 64'(cfg_length);
    endfunction

    function automatic longint unsigned active_modulus();
        return 64'((cfg_modulus < MODULUS_MIN) ? MODULUS_MIN : cfg_modulus);
    endfunction

    function automatic void refresh_pattern_terms();
        longint unsigned m, q, d, h, p;
        int              j;
        m = active_length();
        q = active_modulus();
        d = cfg_radix % q;
        h = 1;
        p = 0;
        for (j = 1; j < m; j++) h = (h * d) % q;
        for (j = 0; j < m; j++) p = (p * d + cfg_pattern[8*j +: 8]) % q;
        lead_power = h;
        pat_hash   = p;
    endfunction

    function automatic void clear_text();
        int j;
        for (j = 0; j < PATTERN_MAX; j++) window_bytes[j] = '0;
        roll_hash  = 0;
        seen_count = 0;
    endfunction

    function automatic void reset_model();
        cfg_pattern = '0;
        cfg_length  = LENGTH_RESET;
        cfg_radix   = RADIX_RESET;
        cfg_modulus = MODULUS_RESET;
        clear_text();
        refresh_pattern_terms();
    endfunction

    function automatic void predict_scan(input logic [BYTE_W-1:0] c, input logic last);
        longint unsigned m, q, d, t, sub, first;
        scan_result_t    r;
        int              j;
        m = active_length();
        q = active_modulus();
        d = cfg_radix % q;
        t = roll_hash % q;
        if (seen_count >= m) begin
            sub = ((window_bytes[m-1] % q) * lead_power) % q;
            t   = (((t + q - sub) % q) * d + c) % q;
        end else begin
            t = (t * d + c) % q;
        end
        roll_hash = t;
        for (j = PATTERN_MAX - 1; j > 0; j--) window_bytes[j] = window_bytes[j-1];
        window_bytes[0] = c;
        if (seen_count < SEEN_LIMIT) seen_count++;
        r      = '0;
        r.hash = t[HASH_W-1:0];
        if (seen_count >= m) begin
            first   = seen_count - m;
            r.full  = 1'b1;
            r.start = (first > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : first[START_W-1:0];
            r.hit   = (t == pat_hash);
            r.match = r.hit;
            for (j = 0; j < m; j++)
                if (window_bytes[m-1-j] != cfg_pattern[8*j +: 8]) r.match = 1'b0;
        end
        predicted_scans.push_back(r);
        if (last) clear_text();
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic write_register(input logic [1:0] reg_sel, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_sel)
            REG_PATTERN: cfg_pattern = value;
            REG_LENGTH:  cfg_length  = value[LEN_W-1:0];
            REG_RADIX:   cfg_radix   = value[HASH_W-1:0];
            REG_MODULUS: cfg_modulus = value[HASH_W-1:0];
            default: ;
        endcase
        refresh_pattern_terms();
    endtask

    task automatic set_search(input logic [PAT_W-1:0] pattern, input logic [LEN_W-1:0] len,
                              input logic [HASH_W-1:0] radix, input logic [HASH_W-1:0] modulus);
        write_register(REG_PATTERN, pattern);
        write_register(REG_LENGTH, 64'(len));
        write_register(REG_RADIX, 64'(radix));
        write_register(REG_MODULUS, 64'(modulus));
    endtask

    task automatic feed_bytes(input logic [63:0] bytes, input int count, input bit close);
        int j;
        @(negedge aclk);
        for (j = 0; j < count; j++)
            text_feed.push_back('{bytes[8*j +: 8], close && (j == count - 1)});
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (text_feed.size() != 0 || s_valid || predicted_scans.size() != 0);
    endtask

    task automatic random_phase(input int n_items, input bit leave_open);
        logic [PAT_W-1:0]  pat;
        logic [LEN_W-1:0]  len;
        logic [HASH_W-1:0] radix;
        logic [HASH_W-1:0] modulus;
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] text[$];
        int                eff, cut, count, text_len, j;
        base = 8'($urandom_range(252));
        for (j = 0; j < PATTERN_MAX; j++) pat[8*j +: 8] = 8'(base + $urandom_range(3));
        if ($urandom_range(7) == 0) pat = {$urandom, $urandom};
        case ($urandom_range(9))
            0: len = 4'd0;
            1: len = 4'($urandom_range(15, 9));
            default: len = 4'($urandom_range(8, 1));
        endcase
        case ($urandom_range(9))
            0: radix = 16'd0;
            1: radix = 16'hFFFF;
            2: radix = 16'($urandom_range(16'hFFFF));
            3: radix = 16'd256;
            default: radix = 16'($urandom_range(300, 1));
        endcase
        case ($urandom_range(9))
            0: modulus = 16'($urandom_range(1));
            1: modulus = 16'hFFFF;
            2, 3, 4: modulus = 16'($urandom_range(13, 2));
            default: modulus = 16'($urandom_range(16'hFFFF, 2));
        endcase
        set_search(pat, len, radix, modulus);
        eff = (len == 0) ? 1 : (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
        @(negedge aclk);
        count = 0;
        while (count < n_items) begin
            text.delete();
            text_len = $urandom_range(40, 1);
            while (text.size() < text_len) begin
                case ($urandom_range(7))
                    0, 1: cut = eff;
                    2: cut = $urandom_range(eff, 1);
                    default: cut = 0;
                endcase
                for (j = 0; j < cut; j++) text.push_back(pat[8*j +: 8]);
                if (cut == 0)
                    text.push_back(8'(($urandom_range(5) == 0) ? $urandom_range(255)
                                                               : base + $urandom_range(3)));
            end
            while (text.size() > n_items - count) text.pop_back();
            count += text.size();
            for (j = 0; j < text.size(); j++)
                text_feed.push_back('{text[j], (j == text.size() - 1)
                                               && !(leave_open && count >= n_items)});
        end
    endtask

    always @(posedge aclk) begin : text_driver
        text_item_t next_item;
        if (aresetn && s_valid && s_ready) predict_scan(s_text_byte, s_end_of_text);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (text_feed.size() != 0 && (no_gaps || $urandom_range(99) >= 19)) begin
                next_item = text_feed.pop_front();
                s_valid       <= 1'b1;
                s_text_byte   <= next_item.value;
                s_end_of_text <= next_item.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        scan_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_scans.size() == 0) begin
                    $error("unexpected result transaction, window_hash %0d", m_window_hash);
                    fail_count++;
                end else begin
                    want = predicted_scans.pop_front();
                    check_field("window_full", 64'(want.full), 64'(m_window_full));
                    check_field("window_hash", 64'(want.hash), 64'(m_window_hash));
                    check_field("hash_hit", 64'(want.hit), 64'(m_hash_hit));
                    check_field("match_found", 64'(want.match), 64'(m_match_found));
                    check_field("match_start", 64'(want.start), 64'(m_match_start));
                end
            end
            if (long_hold_req && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_gaps || ($urandom_range(99) >= 19);
            end
        end
    end

    initial begin : stimulus
        int phase;
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // plain search, window filling and matches
        set_search(64'h0000_0000_0063_6261, 4'd3, 16'd256, 16'd101);
        feed_bytes(64'h0063_6261_6362_6178, 7, 1'b1);
        wait_idle();
        // length above the limit, radix equal to the modulus, all-ones bytes
        set_search(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 16'hFFFF, 16'hFFFF);
        feed_bytes(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b1);
        wait_idle();
        // zero length, zero modulus, zero radix
        set_search(64'd0, 4'd0, 16'd0, 16'd0);
        feed_bytes(64'h0000_0000_0000_0100, 3, 1'b1);
        wait_idle();
        // settings changed in the middle of a text
        set_search(64'h0000_0000_0000_6261, 4'd2, 16'd3, 16'd7);
        feed_bytes(64'h0000_0000_0000_6261, 2, 1'b0);
        wait_idle();
        write_register(REG_RADIX, 64'd5);
        feed_bytes(64'h0000_0000_0000_6261, 2, 1'b1);
        wait_idle();

        for (phase = 0; phase < 24; phase++) begin
            no_gaps       = (phase == 5);
            long_hold_req = (phase == 10);
            random_phase((phase == 10) ? 100 : 48, $urandom_range(3) == 0);
            wait_idle();
        end

        repeat (60) @(posedge aclk);
        if (fail_count == 0 && predicted_scans.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rhpm_pkg.sv
rtl/rhpm_modmul.sv
rtl/rhpm_ctrl.sv
rtl/rhpm_datapath.sv
rtl/rolling_hash_pattern_matcher_core.sv
bench/tb_rolling_hash_pattern_matcher_core.sv
